### rtl/tcon_pkg.sv
// types, constants and codes shared by the text console character engine
`default_nettype none

package tcon_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam int REQ_TYPE_W  = 2;
   localparam int CHAR_W      = 8;
   localparam int COL_IN_W    = 7;
   localparam int ROW_IN_W    = 5;
   localparam int ADDR_IN_W   = 11;
   localparam int POS_W       = 11;
   localparam int ATTR_W      = 8;
   localparam int CELL_DATA_W = 16;

   localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;
   localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CODE_LF        = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_CR        = 8'h0D;
   localparam int TAB_STEP = 8;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PRINT      = 2'd0,
      REQ_CLEAR      = 2'd1,
      REQ_SET_CURSOR = 2'd2,
      REQ_READ       = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MOVE,
      ST_DRAIN,
      ST_FILL,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### rtl/tcon_if.sv
// handshake interfaces for the request, response and csr channels
`default_nettype none

interface tcon_req_if;
   import tcon_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [CHAR_W-1:0]    char_code;
   logic [COL_IN_W-1:0]  cursor_col;
   logic [ROW_IN_W-1:0]  cursor_row;
   logic [ADDR_IN_W-1:0] read_addr;
   modport source (output valid, req_type, char_code, cursor_col, cursor_row, read_addr,
                   input ready);
   modport sink (input valid, req_type, char_code, cursor_col, cursor_row, read_addr,
                 output ready);
endinterface

interface tcon_rsp_if;
   import tcon_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [POS_W-1:0]       cursor_pos;
   logic [CELL_DATA_W-1:0] read_data;
   logic                   scrolled;
   modport source (output valid, cursor_pos, read_data, scrolled, input ready);
   modport sink (input valid, cursor_pos, read_data, scrolled, output ready);
endinterface

interface tcon_csr_if;
   import tcon_pkg::*;
   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] cell_attribute;
   modport source (output valid, cell_attribute, input ready);
   modport sink (input valid, cell_attribute, output ready);
endinterface

`default_nettype wire

### rtl/tcon_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module tcon_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/text_console_char_engine.sv
// text console engine: cell buffer, cursor, print, clear, set cursor and read
//
//  channel   role     payload
//  req_if    sink     req_type, char_code, cursor_col, cursor_row, read_addr
//  rsp_if    source   cursor_pos, read_data, scrolled
//  csr_if    sink     cell_attribute
//
// print without scroll and set cursor: response registered at accept; read: through ST_READ
// (registered ram read); clear: ST_FILL, ST_DONE; print with scroll: ST_MOVE, ST_DRAIN,
// ST_FILL, ST_DONE, one cell moved or blanked per cycle through the single ram write port
// after reset a clearing pass blanks the ram, no requests taken
// a stalled response holds in the output register; the next request waits for it to leave
`default_nettype none

module text_console_char_engine #(
   parameter int COLUMNS = tcon_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcon_pkg::ROWS_DEFAULT
) (
   input wire       clock,
   input wire       reset,
   tcon_req_if.sink   req_if,
   tcon_rsp_if.source rsp_if,
   tcon_csr_if.sink   csr_if
);

   import tcon_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int CELL_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int CE_W   = COL_W + 1;
   localparam int RE_W   = ROW_W + 1;

   state_type              state_ff, state_in;
   logic [COL_W-1:0]       cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]       cur_row_ff, cur_row_in;
   logic [ATTR_W-1:0]      attr_ff;
   logic [CELL_W-1:0]      ptr_ff, ptr_in;
   logic [CELL_W-1:0]      mv_addr_ff, mv_addr_in;
   logic                   mv_pend_ff, mv_pend_in;
   logic                   fill_init_ff, fill_init_in;
   logic                   rd_ok_ff, rd_ok_in;
   logic [CELL_DATA_W-1:0] res_data_ff, res_data_in;
   logic                   res_scr_ff, res_scr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [CELL_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_scr_ff, rsp_scr_in;

   logic                   ram_we;
   logic [CELL_W-1:0]      ram_waddr, ram_raddr;
   logic [CELL_DATA_W-1:0] ram_wdata, ram_rdata;

   logic [CE_W-1:0]        pc_col;
   logic [RE_W-1:0]        pc_row;
   logic                   pc_we, pc_scroll;
   logic [COL_W-1:0]       pc_wcol;
   logic [ROW_W-1:0]       pc_wrow;
   logic [CELL_DATA_W-1:0] pc_wdata;
   logic [CELL_W-1:0]      pc_waddr, pos_lin;
   logic [CELL_DATA_W-1:0] blank_cell;
   logic                   out_free, accept;

   assign blank_cell   = {attr_ff, BLANK_CHAR};
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && out_free;
   assign accept       = req_if.valid && req_if.ready;

   // print: control codes, column wrap, scroll detect
   always_comb begin
      pc_col   = {1'b0, cur_col_ff};
      pc_row   = {1'b0, cur_row_ff};
      pc_we    = 1'b0;
      pc_wcol  = cur_col_ff;
      pc_wrow  = cur_row_ff;
      pc_wdata = blank_cell;
      case (req_if.char_code)
         CODE_BACKSPACE: begin
            if (cur_col_ff != '0 || cur_row_ff != '0) begin
               if (cur_col_ff != '0) begin
                  pc_col  = {1'b0, cur_col_ff} - CE_W'(1);
                  pc_wcol = cur_col_ff - COL_W'(1);
               end else begin
                  pc_row  = {1'b0, cur_row_ff} - RE_W'(1);
                  pc_col  = CE_W'(COLUMNS - 1);
                  pc_wrow = cur_row_ff - ROW_W'(1);
                  pc_wcol = COL_W'(COLUMNS - 1);
               end
               pc_we = 1'b1;
            end
         end
         CODE_TAB: begin
            pc_col = ({1'b0, cur_col_ff} + CE_W'(TAB_STEP)) & ~CE_W'(TAB_STEP - 1);
         end
         CODE_CR: begin
            pc_col = '0;
         end
         CODE_LF: begin
            pc_col = '0;
            pc_row = {1'b0, cur_row_ff} + RE_W'(1);
         end
         default: begin
            if (req_if.char_code >= BLANK_CHAR) begin
               pc_we    = 1'b1;
               pc_wdata = {attr_ff, req_if.char_code};
               pc_col   = {1'b0, cur_col_ff} + CE_W'(1);
            end
         end
      endcase
      if (pc_col >= CE_W'(COLUMNS)) begin
         pc_col = '0;
         pc_row = pc_row + RE_W'(1);
      end
      pc_scroll = (pc_row >= RE_W'(ROWS));
      if (pc_scroll) begin
         pc_row = RE_W'(ROWS - 1);
      end
   end

   assign pc_waddr = CELL_W'(CELL_W'(pc_wrow) * CELL_W'(COLUMNS)) + CELL_W'(pc_wcol);
   assign pos_lin  = CELL_W'(CELL_W'(cur_row_in) * CELL_W'(COLUMNS)) + CELL_W'(cur_col_in);

   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      ptr_in       = ptr_ff;
      mv_addr_in   = ptr_ff;
      mv_pend_in   = 1'b0;
      fill_init_in = fill_init_ff;
      rd_ok_in     = rd_ok_ff;
      res_data_in  = res_data_ff;
      res_scr_in   = res_scr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_scr_in   = rsp_scr_ff;
      ram_we       = 1'b0;
      ram_waddr    = mv_addr_ff;
      ram_wdata    = ram_rdata;
      ram_raddr    = CELL_W'(req_if.read_addr);

      // pending scroll move lands in the cycle after its read
      if (mv_pend_ff) begin
         ram_we = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_data_in = '0;
               res_scr_in  = 1'b0;
               case (req_kind_type'(req_if.req_type))
                  REQ_PRINT: begin
                     cur_col_in = COL_W'(pc_col);
                     cur_row_in = ROW_W'(pc_row);
                     ram_we     = pc_we;
                     ram_waddr  = pc_waddr;
                     ram_wdata  = pc_wdata;
                     if (pc_scroll) begin
                        res_scr_in = 1'b1;
                        ptr_in     = '0;
                        state_in   = ST_MOVE;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                        rsp_scr_in   = 1'b0;
                     end
                  end
                  REQ_CLEAR: begin
                     cur_col_in   = '0;
                     cur_row_in   = '0;
                     ptr_in       = '0;
                     fill_init_in = 1'b0;
                     state_in     = ST_FILL;
                  end
                  REQ_SET_CURSOR: begin
                     if (32'(req_if.cursor_col) < COLUMNS) begin
                        cur_col_in = COL_W'(req_if.cursor_col);
                     end else begin
                        cur_col_in = COL_W'(COLUMNS - 1);
                     end
                     if (32'(req_if.cursor_row) < ROWS) begin
                        cur_row_in = ROW_W'(req_if.cursor_row);
                     end else begin
                        cur_row_in = ROW_W'(ROWS - 1);
                     end
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     rsp_scr_in   = 1'b0;
                  end
                  REQ_READ: begin
                     rd_ok_in = (32'(req_if.read_addr) < CELLS);
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_data_in = rd_ok_ff ? ram_rdata : '0;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_ok_ff ? ram_rdata : '0;
               rsp_scr_in   = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MOVE: begin
            ram_raddr  = ptr_ff + CELL_W'(COLUMNS);
            mv_pend_in = 1'b1;
            ptr_in     = ptr_ff + CELL_W'(1);
            if (ptr_ff == CELL_W'(CELLS - COLUMNS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            ptr_in       = CELL_W'(CELLS - COLUMNS);
            fill_init_in = 1'b0;
            state_in     = ST_FILL;
         end
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ram_wdata = fill_init_ff ? {ATTR_RESET, BLANK_CHAR} : blank_cell;
            ptr_in    = ptr_ff + CELL_W'(1);
            if (ptr_ff == CELL_W'(CELLS - 1)) begin
               state_in = fill_init_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_scr_in   = res_scr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_pos_in = rsp_pos_ff;
      if (rsp_valid_in && out_free) begin
         rsp_pos_in = POS_W'(pos_lin);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         attr_ff      <= ATTR_RESET;
         ptr_ff       <= '0;
         mv_pend_ff   <= 1'b0;
         fill_init_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         ptr_ff       <= ptr_in;
         mv_pend_ff   <= mv_pend_in;
         fill_init_ff <= fill_init_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid) begin
            attr_ff <= csr_if.cell_attribute;
         end
      end
   end

   always_ff @(posedge clock) begin
      mv_addr_ff  <= mv_addr_in;
      rd_ok_ff    <= rd_ok_in;
      res_data_ff <= res_data_in;
      res_scr_ff  <= res_scr_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   assign csr_if.ready      = 1'b1;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.cursor_pos = rsp_pos_ff;
   assign rsp_if.read_data  = rsp_data_ff;
   assign rsp_if.scrolled   = rsp_scr_ff;

   tcon_ram #(
      .WIDTH (CELL_DATA_W),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire
